### rtl/ppeerl_pkg.sv
package ppeerl_pkg;

   // sizing
   localparam int SLOTS_PER_PIN = 128;
   localparam int PIN_COUNT     = 29;
   localparam int MEM_DEPTH     = PIN_COUNT * SLOTS_PER_PIN;
   localparam int ADDR_W        = $clog2(MEM_DEPTH);
   localparam int SLOT_W        = $clog2(SLOTS_PER_PIN);
   localparam int CNT_W         = $clog2(SLOTS_PER_PIN + 1);
   localparam int PIN_IDX_W     = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

   // port field widths
   localparam int CMD_W   = 3;
   localparam int PIN_W   = 5;
   localparam int FLAGS_W = 4;
   localparam int TIME_W  = 32;
   localparam int LEFT_W  = 8;

   localparam logic [FLAGS_W-1:0] RISE_MASK = 4'h4;

   typedef enum logic [CMD_W-1:0] {
      CMD_EDGE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_POP   = 3'd3,
      CMD_QUERY = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;     // item transfers this edge
      logic load_rd;  // capture popped entry into result register
   } dp_ctl_type;

   // datapath to controller
   typedef struct packed {
      logic no_result; // edge event or unused code
      logic pop_hit;   // pop of a stored entry, needs a memory read
   } dp_stat_type;

endpackage

### rtl/ppeerl_ctrl.sv
module ppeerl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ppeerl_pkg::dp_stat_type stat,
   output ppeerl_pkg::dp_ctl_type  ctl
);
   import ppeerl_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      take;

   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_RESP) && rsp_ready);
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE, ST_RESP: begin
            if (take) begin
               if (stat.pop_hit) begin
                  state_in = ST_READ;
               end else if (stat.no_result) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RESP;
               end
            end else if ((state_ff == ST_RESP) && rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl.take    = take;
      ctl.load_rd = (state_ff == ST_READ);
      rsp_valid   = (state_ff == ST_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/ppeerl_dp.sv
module ppeerl_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [ppeerl_pkg::CMD_W-1:0]         req_command,
   input  logic [ppeerl_pkg::PIN_W-1:0]         req_pin,
   input  logic [ppeerl_pkg::FLAGS_W-1:0]       req_edge_flags,
   input  logic [ppeerl_pkg::TIME_W-1:0]        req_timestamp_ms,
   output logic                                 rsp_entry_valid,
   output logic [ppeerl_pkg::TIME_W-1:0]        rsp_event_time_ms,
   output logic                                 rsp_event_rising,
   output logic [ppeerl_pkg::LEFT_W-1:0]        rsp_events_left,
   output logic                                 rsp_pin_active,
   input  ppeerl_pkg::dp_ctl_type               ctl,
   output ppeerl_pkg::dp_stat_type              stat
);
   import ppeerl_pkg::*;

   // per-pin ring state
   logic [SLOT_W-1:0] wpos_ff [PIN_COUNT];
   logic [CNT_W-1:0]  count_ff [PIN_COUNT];
   logic              enable_ff [PIN_COUNT];

   // event store, no reset
   logic [TIME_W:0]   mem [MEM_DEPTH];
   logic [TIME_W:0]   rd_data_ff;

   // result register
   logic              valid_ff;
   logic [TIME_W-1:0] time_ff;
   logic              rising_ff;
   logic [CNT_W-1:0]  left_ff;
   logic              active_ff;

   logic                 pin_ok;
   logic [PIN_IDX_W-1:0] pidx;
   logic [SLOT_W-1:0]    cur_wpos;
   logic [CNT_W-1:0]     cur_count;
   logic                 cur_enable;
   logic [CNT_W:0]       wpos_ext;
   logic [CNT_W:0]       pop_diff;
   logic [SLOT_W-1:0]    pop_idx;
   logic [SLOT_W-1:0]    wpos_next;
   logic [ADDR_W-1:0]    mem_addr;
   logic                 is_edge;
   logic                 is_start;
   logic                 is_stop;
   logic                 is_pop;
   logic                 is_unused;
   logic                 do_write;
   logic                 do_read;

   assign pin_ok     = {1'b0, req_pin} < (PIN_W + 1)'(PIN_COUNT);
   assign pidx       = PIN_IDX_W'(req_pin);
   assign cur_wpos   = wpos_ff[pidx];
   assign cur_count  = count_ff[pidx];
   assign cur_enable = enable_ff[pidx];

   assign is_edge   = (req_command == CMD_EDGE);
   assign is_start  = (req_command == CMD_START);
   assign is_stop   = (req_command == CMD_STOP);
   assign is_pop    = (req_command == CMD_POP);
   assign is_unused = (req_command > CMD_QUERY);

   // oldest entry sits count slots behind the write position
   assign wpos_ext = (CNT_W + 1)'(cur_wpos);
   always_comb begin
      if (wpos_ext >= {1'b0, cur_count}) begin
         pop_diff = wpos_ext - {1'b0, cur_count};
      end else begin
         pop_diff = wpos_ext + (CNT_W + 1)'(SLOTS_PER_PIN) - {1'b0, cur_count};
      end
   end
   assign pop_idx = SLOT_W'(pop_diff);

   assign wpos_next = (cur_wpos == SLOT_W'(SLOTS_PER_PIN - 1)) ? '0 : cur_wpos + 1'b1;

   assign mem_addr = ADDR_W'(ADDR_W'(pidx) * ADDR_W'(SLOTS_PER_PIN))
                   + ADDR_W'(is_edge ? cur_wpos : pop_idx);

   assign stat.no_result = is_edge || is_unused;
   assign stat.pop_hit   = is_pop && pin_ok && (cur_count != '0);

   assign do_write = ctl.take && is_edge && pin_ok && cur_enable;
   assign do_read  = ctl.take && stat.pop_hit;

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[mem_addr] <= {req_timestamp_ms, (req_edge_flags & RISE_MASK) != '0};
      end
      if (do_read) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIN_COUNT; i++) begin
            wpos_ff[i]   <= '0;
            count_ff[i]  <= '0;
            enable_ff[i] <= 1'b0;
         end
      end else if (ctl.take && pin_ok) begin
         if (do_write) begin
            wpos_ff[pidx] <= wpos_next;
            if (cur_count != CNT_W'(SLOTS_PER_PIN)) begin
               count_ff[pidx] <= cur_count + 1'b1;
            end
         end else if (is_start) begin
            wpos_ff[pidx]   <= '0;
            count_ff[pidx]  <= '0;
            enable_ff[pidx] <= 1'b1;
         end else if (is_stop) begin
            enable_ff[pidx] <= 1'b0;
         end else if (stat.pop_hit) begin
            count_ff[pidx] <= cur_count - 1'b1;
         end
      end
   end

   // result fields settle at transfer; a popped entry is loaded from rd_data_ff in the read state
   always_ff @(posedge clock) begin
      if (ctl.take) begin
         time_ff   <= '0;
         rising_ff <= 1'b0;
         if (!pin_ok) begin
            valid_ff  <= 1'b0;
            left_ff   <= '0;
            active_ff <= 1'b0;
         end else if (is_start) begin
            valid_ff  <= 1'b0;
            left_ff   <= '0;
            active_ff <= 1'b1;
         end else if (is_stop) begin
            valid_ff  <= 1'b0;
            left_ff   <= cur_count;
            active_ff <= 1'b0;
         end else if (stat.pop_hit) begin
            valid_ff  <= 1'b1;
            left_ff   <= cur_count - 1'b1;
            active_ff <= cur_enable;
         end else begin
            valid_ff  <= 1'b0;
            left_ff   <= cur_count;
            active_ff <= cur_enable;
         end
      end else if (ctl.load_rd) begin
         time_ff   <= rd_data_ff[TIME_W:1];
         rising_ff <= rd_data_ff[0];
      end
   end

   assign rsp_entry_valid   = valid_ff;
   assign rsp_event_time_ms = time_ff;
   assign rsp_event_rising  = rising_ff;
   assign rsp_events_left   = LEFT_W'(left_ff);
   assign rsp_pin_active    = active_ff;

endmodule

### rtl/per_pin_edge_event_ring_log_top.sv
// per-pin edge event ring log
//
// request channel (req_*): one command per transfer. edge events are logged
// into the pin's ring when the pin is in range and active; start clears and
// activates a ring, stop deactivates it, pop removes the oldest entry, query
// reports the active flag and stored count.
// response channel (rsp_*): one transfer for start, stop, pop and query;
// edge events and unused command codes give none.
//
// after an edge event the controller is idle and req_ready stays high.
// start, stop, query and a pop of an empty ring show rsp_valid the cycle
// after the request transfer. a pop that hits a stored entry needs one
// event-store read and goes through the read state before rsp_valid shows.
// throughput: one edge event per cycle while req_ready is high; a command
// with a response holds one item in flight, and the next request can
// transfer in the same cycle as the response. a stalled receiver holds rsp_*
// and keeps req_ready low. reset clears all ring pointers, counts and active
// flags at once; the event store itself is not cleared and needs no sweep.
module per_pin_edge_event_ring_log_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ppeerl_pkg::CMD_W-1:0]       req_command,
   input  logic [ppeerl_pkg::PIN_W-1:0]       req_pin,
   input  logic [ppeerl_pkg::FLAGS_W-1:0]     req_edge_flags,
   input  logic [ppeerl_pkg::TIME_W-1:0]      req_timestamp_ms,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_entry_valid,
   output logic [ppeerl_pkg::TIME_W-1:0]      rsp_event_time_ms,
   output logic                               rsp_event_rising,
   output logic [ppeerl_pkg::LEFT_W-1:0]      rsp_events_left,
   output logic                               rsp_pin_active
);
   import ppeerl_pkg::*;

   dp_ctl_type  ctl;
   dp_stat_type stat;

   // sequencing of transfers and the event-store read
   ppeerl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // ring state, event store and response register
   ppeerl_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_pin           (req_pin),
      .req_edge_flags    (req_edge_flags),
      .req_timestamp_ms  (req_timestamp_ms),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_event_time_ms (rsp_event_time_ms),
      .rsp_event_rising  (rsp_event_rising),
      .rsp_events_left   (rsp_events_left),
      .rsp_pin_active    (rsp_pin_active),
      .ctl               (ctl),
      .stat              (stat)
   );

endmodule

### rtl/ppeerl_checker.sv
module ppeerl_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [ppeerl_pkg::CMD_W-1:0]       req_command,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_entry_valid,
   input logic [ppeerl_pkg::TIME_W-1:0]      rsp_event_time_ms,
   input logic                               rsp_event_rising,
   input logic [ppeerl_pkg::LEFT_W-1:0]      rsp_events_left,
   input logic                               rsp_pin_active
);
   import ppeerl_pkg::*;

   // stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_events_left)
         && $stable(rsp_event_time_ms) && $stable(rsp_entry_valid)
         && $stable(rsp_event_rising) && $stable(rsp_pin_active))
      else $error("response changed while stalled");

   // one item in flight: a pending response blocks new requests until taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response pending");

   // no stored event means empty event fields
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_event_time_ms == '0 && !rsp_event_rising)
      else $error("event fields set without a popped entry");

   // count never exceeds the ring size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_events_left <= LEFT_W'(SLOTS_PER_PIN))
      else $error("stored count beyond ring size");

   // an edge event transfer never produces a response next cycle
   a_edge_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_EDGE |=> !rsp_valid)
      else $error("response after edge event");

endmodule

bind per_pin_edge_event_ring_log_top ppeerl_checker u_checker (.*);

### verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppeerl_pkg::*;

   // pin numbers and code ranges used by the stimulus
   localparam int LAST_PIN       = PIN_COUNT - 1;
   localparam int TOP_PIN_CODE   = (1 << PIN_W) - 1;
   localparam int LAST_CMD_CODE  = (1 << CMD_W) - 1;
   localparam int FILL_PIN       = 3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 10;

   // one response as seen on the rsp_* ports
   typedef struct packed {
      logic                entry_valid;
      logic [TIME_W-1:0]   event_time_ms;
      logic                event_rising;
      logic [LEFT_W-1:0]   events_left;
      logic                pin_active;
   } ring_rsp_type;

   // tracks every pin's ring and queues the replies the block owes
   class edge_ring_tracker_type;
      logic [TIME_W-1:0] slot_time [PIN_COUNT][SLOTS_PER_PIN];
      logic              slot_rise [PIN_COUNT][SLOTS_PER_PIN];
      int unsigned       wr_slot [PIN_COUNT];
      int unsigned       fill [PIN_COUNT];
      bit                armed [PIN_COUNT];
      ring_rsp_type      pending_replies [$];
      int                mismatches;

      function new();
         for (int p = 0; p < PIN_COUNT; p++) begin
            wr_slot[p] = 0;
            fill[p]    = 0;
            armed[p]   = 1'b0;
            for (int s = 0; s < SLOTS_PER_PIN; s++) begin
               slot_time[p][s] = '0;
               slot_rise[p][s] = 1'b0;
            end
         end
         mismatches = 0;
      endfunction

      // update the rings for one accepted request and queue its reply, if it has one
      function void log_request(logic [CMD_W-1:0] cmd, logic [PIN_W-1:0] pin,
                                logic [FLAGS_W-1:0] flags, logic [TIME_W-1:0] stamp);
         ring_rsp_type reply;
         int unsigned  p;
         int unsigned  oldest;
         bit           in_range;
         reply    = '0;
         p        = 32'(pin);
         in_range = (p < PIN_COUNT);
         if (cmd > CMD_QUERY) return;
         if (cmd == CMD_EDGE) begin
            if (in_range && armed[p]) begin
               slot_time[p][wr_slot[p]] = stamp;
               slot_rise[p][wr_slot[p]] = ((flags & RISE_MASK) != '0);
               wr_slot[p] = (wr_slot[p] + 1) % SLOTS_PER_PIN;
               if (fill[p] < SLOTS_PER_PIN) fill[p]++;
            end
            return;
         end
         if (in_range) begin
            case (cmd)
               CMD_START: begin
                  wr_slot[p] = 0;
                  fill[p]    = 0;
                  armed[p]   = 1'b1;
               end
               CMD_STOP: armed[p] = 1'b0;
               CMD_POP: begin
                  if (fill[p] != 0) begin
                     oldest = (wr_slot[p] + SLOTS_PER_PIN - fill[p]) % SLOTS_PER_PIN;
                     fill[p]--;
                     reply.entry_valid   = 1'b1;
                     reply.event_time_ms = slot_time[p][oldest];
                     reply.event_rising  = slot_rise[p][oldest];
                  end
               end
               default: ;
            endcase
            reply.events_left = LEFT_W'(fill[p]);
            reply.pin_active  = armed[p];
         end
         pending_replies.push_back(reply);
      endfunction

      function void check_response(ring_rsp_type got);
         ring_rsp_type want;
         if (pending_replies.size() == 0) begin
            $error("response transfer with no reply pending");
            mismatches++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.entry_valid !== want.entry_valid) begin
            $error("entry_valid: expected %0d, got %0d", want.entry_valid, got.entry_valid);
            mismatches++;
         end
         if (got.event_time_ms !== want.event_time_ms) begin
            $error("event_time_ms: expected %0h, got %0h",
                   want.event_time_ms, got.event_time_ms);
            mismatches++;
         end
         if (got.event_rising !== want.event_rising) begin
            $error("event_rising: expected %0d, got %0d", want.event_rising, got.event_rising);
            mismatches++;
         end
         if (got.events_left !== want.events_left) begin
            $error("events_left: expected %0d, got %0d", want.events_left, got.events_left);
            mismatches++;
         end
         if (got.pin_active !== want.pin_active) begin
            $error("pin_active: expected %0d, got %0d", want.pin_active, got.pin_active);
            mismatches++;
         end
      endfunction
   endclass

   // clock, reset and block ports, all known from time zero
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command = '0;
   logic [PIN_W-1:0]    req_pin = '0;
   logic [FLAGS_W-1:0]  req_edge_flags = '0;
   logic [TIME_W-1:0]   req_timestamp_ms = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_entry_valid;
   logic [TIME_W-1:0]   rsp_event_time_ms;
   logic                rsp_event_rising;
   logic [LEFT_W-1:0]   rsp_events_left;
   logic                rsp_pin_active;

   edge_ring_tracker_type rings = new();

   // idle control: quiet_phase turns off all idling near the end of the run
   bit quiet_phase = 1'b0;
   int req_calm = 0;
   int rsp_calm = 0;
   int rsp_stall = 0;
   int stall_roll;
   int idle_cycles = 0;

   per_pin_edge_event_ring_log_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_pin           (req_pin),
      .req_edge_flags    (req_edge_flags),
      .req_timestamp_ms  (req_timestamp_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_event_time_ms (rsp_event_time_ms),
      .rsp_event_rising  (rsp_event_rising),
      .rsp_events_left   (rsp_events_left),
      .rsp_pin_active    (rsp_pin_active)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // one request transfer, with an optional idle burst in front of it
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PIN_W-1:0] pin,
                            input logic [FLAGS_W-1:0] flags,
                            input logic [TIME_W-1:0] stamp);
      int gap;
      if (!quiet_phase) begin
         if (req_calm > 0) begin
            req_calm--;
         end else if ($urandom_range(0, 99) < 15) begin
            // valid drops for a burst, then the next item goes out
            gap = $urandom_range(1, 10);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else if ($urandom_range(0, 99) < 3) begin
            // a stretch of back-to-back items
            req_calm = $urandom_range(20, 80);
         end
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_pin          <= pin;
      req_edge_flags   <= flags;
      req_timestamp_ms <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // transfer happened at this edge
      rings.log_request(cmd, pin, flags, stamp);
   endtask

   // response side: check each transfer, then pick the next ready value
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rings.check_response(ring_rsp_type'{rsp_entry_valid, rsp_event_time_ms,
                                                rsp_event_rising, rsp_events_left,
                                                rsp_pin_active});
         end
         if (quiet_phase || rsp_calm > 0) begin
            if (rsp_calm > 0) rsp_calm--;
            rsp_ready <= 1'b1;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 12) begin
               // start a stall burst that includes this cycle
               rsp_stall = $urandom_range(1, 10) - 1;
               rsp_ready <= 1'b0;
            end else begin
               if (stall_roll < 15) rsp_calm = $urandom_range(20, 80);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // watchdog: too long without any transfer on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int          hot_pins [4];
      int          roll;
      int          pin_pick;
      logic [CMD_W-1:0] cmd_pick;

      hot_pins = '{0, 1, LAST_PIN - 1, LAST_PIN};

      // synchronous reset, applied once at the start
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: inactive pin, first and last pins, field extremes
      send_item(CMD_QUERY, '0, '0, '0);
      send_item(CMD_POP, '0, '0, '0);                     // pop on empty ring
      send_item(CMD_EDGE, '0, 4'hF, 32'h1234_5678);       // edge on inactive pin
      send_item(CMD_START, '0, '0, '0);
      send_item(CMD_START, PIN_W'(LAST_PIN), '0, '0);
      send_item(CMD_EDGE, '0, 4'hF, '1);
      send_item(CMD_EDGE, '0, 4'h0, '0);
      send_item(CMD_EDGE, PIN_W'(LAST_PIN), RISE_MASK, 32'h8000_0001);
      send_item(CMD_EDGE, PIN_W'(LAST_PIN), ~RISE_MASK, 32'h7FFF_FFFE);
      // out-of-range pins are ignored and answer with zeros
      send_item(CMD_START, PIN_W'(TOP_PIN_CODE), '0, '0);
      send_item(CMD_EDGE, PIN_W'(PIN_COUNT), 4'hF, '1);
      send_item(CMD_STOP, PIN_W'(PIN_COUNT + 1), '0, '0);
      send_item(CMD_POP, PIN_W'(TOP_PIN_CODE), '0, '0);
      send_item(CMD_QUERY, PIN_W'(PIN_COUNT), '0, '0);
      // unused command codes give no response
      for (int c = CMD_QUERY + 1; c <= LAST_CMD_CODE; c++)
         send_item(CMD_W'(c), '0, 4'hF, '1);
      send_item(CMD_QUERY, '0, '0, '0);
      send_item(CMD_POP, '0, '0, '0);
      // stop keeps contents, edges then ignored, pop still works
      send_item(CMD_STOP, PIN_W'(LAST_PIN), '0, '0);
      send_item(CMD_EDGE, PIN_W'(LAST_PIN), 4'hF, 32'hDEAD_BEEF);
      send_item(CMD_POP, PIN_W'(LAST_PIN), '0, '0);
      send_item(CMD_QUERY, PIN_W'(LAST_PIN), '0, '0);
      // repeated start clears the ring
      send_item(CMD_START, '0, '0, '0);
      send_item(CMD_POP, '0, '0, '0);
      send_item(CMD_POP, PIN_W'(LAST_PIN), '0, '0);

      // fill one ring well past its size so it wraps and overwrites
      send_item(CMD_START, PIN_W'(FILL_PIN), '0, '0);
      for (int i = 0; i < 320; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 90) cmd_pick = CMD_EDGE;
         else if (roll < 95) cmd_pick = CMD_POP;
         else cmd_pick = CMD_QUERY;
         send_item(cmd_pick, PIN_W'(FILL_PIN), FLAGS_W'($urandom_range(0, 15)), $urandom());
      end
      // drain it with pops, some queries mixed in
      for (int i = 0; i < 140; i++) begin
         cmd_pick = ($urandom_range(0, 9) == 0) ? CMD_QUERY : CMD_POP;
         send_item(cmd_pick, PIN_W'(FILL_PIN), FLAGS_W'($urandom_range(0, 15)), $urandom());
      end

      // mixed traffic, mostly on a few hot pins
      for (int i = 0; i < 650; i++) begin
         if (i == 500) quiet_phase = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 50) cmd_pick = CMD_EDGE;
         else if (roll < 53) cmd_pick = CMD_START;
         else if (roll < 56) cmd_pick = CMD_STOP;
         else if (roll < 86) cmd_pick = CMD_POP;
         else if (roll < 94) cmd_pick = CMD_QUERY;
         else cmd_pick = CMD_W'($urandom_range(CMD_QUERY + 1, LAST_CMD_CODE));
         if ($urandom_range(0, 9) < 3) pin_pick = $urandom_range(0, TOP_PIN_CODE);
         else pin_pick = hot_pins[$urandom_range(0, 3)];
         send_item(cmd_pick, PIN_W'(pin_pick), FLAGS_W'($urandom_range(0, 15)), $urandom());
      end
      req_valid <= 1'b0;

      // wait for every owed reply, then a short tail for strays
      while (rings.pending_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (rings.mismatches == 0 && rings.pending_replies.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
